// File: hdl/estc_pkg.sv
// ============================================================================
// estc_pkg: shared types and constants of the trim compensation pipeline
// Holds the sideband record that travels beside the pressure divider, the
// result record and the configuration register indexes.
// ============================================================================
`default_nettype none

package estc_pkg;

    // Width of the pressure quotient datapath.
    localparam int DIV_W = 64;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CAL_A0 = 3'd0;
    localparam logic [2:0] CFG_CAL_A1 = 3'd1;
    localparam logic [2:0] CFG_CAL_A2 = 3'd2;
    localparam logic [2:0] CFG_CAL_A3 = 3'd3;
    localparam logic [2:0] CFG_CAL_B  = 3'd4;

    // Humidity upper bound before the final shift (100 %RH).
    localparam logic [31:0] HUM_CLAMP = 32'd419430400;

    // Fields that ride along with the division.
    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [31:0] tc;
        logic [31:0] tf;
        logic [16:0] hum;
    } t_side;

    // One finished result.
    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic [31:0] press_q24_8;
        logic [16:0] hum_q22_10;
        logic [23:0] press_pa;
        logic [13:0] hum_centi;
        logic        press_invalid;
    } t_res;

endpackage

`default_nettype wire

// File: hdl/env_sensor_trim_compensation.sv
// ============================================================================
// env_sensor_trim_compensation: integer compensation of one raw measurement
// Turns raw temperature, pressure and humidity codes into fine temperature,
// 0.01 degC temperature, Q24.8 pressure and clamped Q22.10 humidity, using
// factory trim words unpacked from the calibration registers.
// ============================================================================
//
//  Channel   Direction  Handshake                    Payload
//  --------  ---------  ---------------------------  ---------------------------
//  in        request    i_in_valid / o_in_ready      i_adc_temp, i_adc_press,
//                                                    i_adc_hum
//  out       result     o_out_valid / i_out_ready    o_temp_centi ... o_press_invalid
//  cfg       write      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// One request can be accepted every cycle while the skid register is empty.
// A request's result passes through ten arithmetic stages, the 64-stage pressure
// divider (one quotient bit per stage), five stages after the division and
// the output register. The reset is synchronous and active low; it clears
// the valid bits and the calibration registers. A stalled output fills a
// one-entry skid register first, so the next result is still taken while one
// waits; only when the skid register is full does the whole pipeline hold.
// ============================================================================
`default_nettype none

module env_sensor_trim_compensation import estc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // Measurement requests.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [19:0] i_adc_temp,
    input  logic [19:0] i_adc_press,
    input  logic [15:0] i_adc_hum,
    // Results.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_temp_centi,
    output logic signed [31:0] o_fine_temp,
    output logic [31:0] o_press_q24_8,
    output logic [16:0] o_hum_q22_10,
    output logic [23:0] o_press_pa,
    output logic [13:0] o_hum_centi,
    output logic        o_press_invalid
);

    // ------------------------------------------------------------------------
    // Calibration registers and trim word unpacking (pure wiring).
    // ------------------------------------------------------------------------
    logic [63:0] r_cal_a0;
    logic [63:0] r_cal_a1;
    logic [63:0] r_cal_a2;
    logic [15:0] r_cal_a3;
    logic [55:0] r_cal_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a0 <= '0;
            r_cal_a1 <= '0;
            r_cal_a2 <= '0;
            r_cal_a3 <= '0;
            r_cal_b  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAL_A0: r_cal_a0 <= i_cfg_data;
                CFG_CAL_A1: r_cal_a1 <= i_cfg_data;
                CFG_CAL_A2: r_cal_a2 <= i_cfg_data;
                CFG_CAL_A3: r_cal_a3 <= i_cfg_data[15:0];
                CFG_CAL_B:  r_cal_b  <= i_cfg_data[55:0];
                default: ;
            endcase
        end
    end

    logic [15:0]        tr_t1;
    logic signed [15:0] tr_t2, tr_t3;
    logic [15:0]        tr_p1;
    logic signed [15:0] tr_p2, tr_p3, tr_p4, tr_p5, tr_p6, tr_p7, tr_p8, tr_p9;
    logic [7:0]         tr_h1, tr_h3;
    logic signed [15:0] tr_h2;
    logic signed [11:0] tr_h4, tr_h5;
    logic signed [7:0]  tr_h6;

    assign tr_t1 = r_cal_a0[15:0];
    assign tr_t2 = r_cal_a0[31:16];
    assign tr_t3 = r_cal_a0[47:32];
    assign tr_p1 = r_cal_a0[63:48];
    assign tr_p2 = r_cal_a1[15:0];
    assign tr_p3 = r_cal_a1[31:16];
    assign tr_p4 = r_cal_a1[47:32];
    assign tr_p5 = r_cal_a1[63:48];
    assign tr_p6 = r_cal_a2[15:0];
    assign tr_p7 = r_cal_a2[31:16];
    assign tr_p8 = r_cal_a2[47:32];
    assign tr_p9 = r_cal_a2[63:48];
    assign tr_h1 = r_cal_a3[15:8];
    assign tr_h2 = r_cal_b[15:0];
    assign tr_h3 = r_cal_b[23:16];
    // H4 and H5 share the nibbles of the fifth byte of the second block.
    assign tr_h4 = {r_cal_b[31:24], r_cal_b[35:32]};
    assign tr_h5 = {r_cal_b[47:40], r_cal_b[39:36]};
    assign tr_h6 = r_cal_b[55:48];

    // ------------------------------------------------------------------------
    // Pipeline enable: everything advances unless the skid register is full.
    // ------------------------------------------------------------------------
    logic r_skid_vld;
    logic en;

    assign en         = ~r_skid_vld;
    assign o_in_ready = en;

    logic [9:0] r_vs;   // valid bits of stages 1 to 10
    logic [4:0] r_vp;   // valid bits of the stages after the divider
    logic       div_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= '0;
            r_vp <= '0;
        end else if (en) begin
            r_vs <= {r_vs[8:0], i_in_valid};
            r_vp <= {r_vp[3:0], div_vld};
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: temperature differences and their first products.
    // ------------------------------------------------------------------------
    logic signed [16:0] c1_d;
    logic signed [17:0] c1_e;
    logic signed [31:0] c1_em, c1_v1, c1_dd;

    assign c1_d  = $signed({1'b0, i_adc_temp[19:4]}) - $signed({1'b0, tr_t1});
    assign c1_e  = $signed({1'b0, i_adc_temp[19:3]}) - $signed({1'b0, tr_t1, 1'b0});
    assign c1_em = 32'(c1_e) * 32'(tr_t2);
    assign c1_v1 = c1_em >>> 11;
    assign c1_dd = 32'(c1_d) * 32'(c1_d);

    logic signed [31:0] r1_v1, r1_dd;
    logic [19:0]        r1_ap;
    logic [15:0]        r1_ah;

    // ------------------------------------------------------------------------
    // Stage 2: quadratic term and fine temperature.
    // ------------------------------------------------------------------------
    logic signed [31:0] c2_dd12, c2_m, c2_v2, c2_tf;

    assign c2_dd12 = r1_dd >>> 12;
    assign c2_m    = c2_dd12 * 32'(tr_t3);
    assign c2_v2   = c2_m >>> 14;
    assign c2_tf   = r1_v1 + c2_v2;

    logic signed [31:0] r2_tf;
    logic [19:0]        r2_ap;
    logic [15:0]        r2_ah;

    // ------------------------------------------------------------------------
    // Stage 3: centi-degrees and the offsets used by pressure and humidity.
    // ------------------------------------------------------------------------
    logic [31:0]        c3_t5;
    logic signed [31:0] c3_tc;
    logic signed [32:0] c3_x;
    logic [31:0]        c3_hv;

    assign c3_t5 = {r2_tf[29:0], 2'b00} + r2_tf + 32'd128;
    assign c3_tc = $signed(c3_t5) >>> 8;
    assign c3_x  = $signed({r2_tf[31], r2_tf}) - 33'sd128000;
    assign c3_hv = r2_tf - 32'd76800;

    logic signed [31:0] r3_tc, r3_tf;
    logic signed [32:0] r3_x;
    logic [31:0]        r3_hv;
    logic [19:0]        r3_ap;
    logic [15:0]        r3_ah;

    // ------------------------------------------------------------------------
    // Stage 4: square of the pressure offset, linear pressure terms and the
    // first humidity products.
    // ------------------------------------------------------------------------
    logic signed [63:0] c4_sq, c4_xp5, c4_xp2;
    logic signed [31:0] c4_h5v, c4_b1m, c4_b1, c4_b2m, c4_b2s, c4_b2;

    assign c4_sq  = 64'(r3_x) * 64'(r3_x);
    assign c4_xp5 = 64'(r3_x) * 64'(tr_p5);
    assign c4_xp2 = 64'(r3_x) * 64'(tr_p2);
    assign c4_h5v = 32'(tr_h5) * $signed(r3_hv);
    assign c4_b1m = $signed(r3_hv) * 32'(tr_h6);
    assign c4_b1  = c4_b1m >>> 10;
    assign c4_b2m = $signed(r3_hv) * $signed({24'd0, tr_h3});
    assign c4_b2s = c4_b2m >>> 11;
    assign c4_b2  = c4_b2s + 32'sd32768;

    logic signed [63:0] r4_sq, r4_xp5, r4_xp2;
    logic signed [31:0] r4_h5v, r4_b1, r4_b2, r4_tc, r4_tf;
    logic [19:0]        r4_ap;
    logic [15:0]        r4_ah;

    // ------------------------------------------------------------------------
    // Stage 5: quadratic pressure products, humidity offset term.
    // ------------------------------------------------------------------------
    logic signed [63:0] c5_x2a, c5_y1;
    logic [31:0]        c5_asum;
    logic signed [31:0] c5_a, c5_bm, c5_bs, c5_b3;

    assign c5_x2a  = r4_sq * 64'(tr_p6);
    assign c5_y1   = r4_sq * 64'(tr_p3);
    assign c5_asum = {2'b00, r4_ah, 14'd0} - {tr_h4, 20'd0} - r4_h5v + 32'd16384;
    assign c5_a    = $signed(c5_asum) >>> 15;
    assign c5_bm   = r4_b1 * r4_b2;
    assign c5_bs   = c5_bm >>> 10;
    assign c5_b3   = c5_bs + 32'sd2097152;

    logic signed [63:0] r5_x2a, r5_y1, r5_xp5, r5_xp2;
    logic signed [31:0] r5_a, r5_b3, r5_tc, r5_tf;
    logic [19:0]        r5_ap;

    // ------------------------------------------------------------------------
    // Stage 6: sum the pressure numerator offset and divisor terms.
    // ------------------------------------------------------------------------
    logic [63:0]        c6_x2, c6_y;
    logic signed [63:0] c6_y1s;
    logic signed [31:0] c6_hm, c6_hb;

    assign c6_x2  = r5_x2a + {r5_xp5[46:0], 17'd0}
                  + {{13{tr_p4[15]}}, tr_p4, 35'd0};
    assign c6_y1s = r5_y1 >>> 8;
    assign c6_y   = c6_y1s + {r5_xp2[51:0], 12'd0};
    assign c6_hm  = r5_b3 * 32'(tr_h2) + 32'sd8192;
    assign c6_hb  = c6_hm >>> 14;

    logic [63:0]        r6_x2, r6_y;
    logic signed [31:0] r6_a, r6_hb, r6_tc, r6_tf;
    logic [19:0]        r6_ap;

    // ------------------------------------------------------------------------
    // Stage 7: divisor scaling by P1, numerator before scaling.
    // ------------------------------------------------------------------------
    logic [63:0]        c7_yy, c7_zm, c7_nm;
    logic signed [63:0] c7_z;
    logic [20:0]        c7_p;
    logic signed [31:0] c7_hv2;

    assign c7_yy  = r6_y + 64'h0000_8000_0000_0000;
    assign c7_zm  = c7_yy * {48'd0, tr_p1};
    assign c7_z   = $signed(c7_zm) >>> 33;
    assign c7_p   = 21'd1048576 - {1'b0, r6_ap};
    assign c7_nm  = {12'd0, c7_p, 31'd0} - r6_x2;
    assign c7_hv2 = r6_a * r6_hb;

    logic [63:0]        r7_nm;
    logic signed [63:0] r7_z;
    logic signed [31:0] r7_hv2, r7_tc, r7_tf;

    // ------------------------------------------------------------------------
    // Stage 8: numerator scaling, humidity self-product.
    // ------------------------------------------------------------------------
    logic [63:0]        c8_num;
    logic signed [31:0] c8_s, c8_ss, c8_ss7;

    assign c8_num = r7_nm * 64'd3125;
    assign c8_s   = r7_hv2 >>> 15;
    assign c8_ss  = c8_s * c8_s;
    assign c8_ss7 = c8_ss >>> 7;

    logic [63:0]        r8_num;
    logic signed [63:0] r8_z;
    logic signed [31:0] r8_hv2, r8_ss7, r8_tc, r8_tf;

    // ------------------------------------------------------------------------
    // Stage 9: operand magnitudes and quotient sign, humidity H1 product.
    // ------------------------------------------------------------------------
    logic [63:0]        c9_mn, c9_md;
    logic signed [31:0] c9_hm, c9_hsub;

    assign c9_mn   = r8_num[63] ? (64'd0 - r8_num) : r8_num;
    assign c9_md   = r8_z[63] ? (64'd0 - r8_z) : r8_z;
    assign c9_hm   = r8_ss7 * $signed({24'd0, tr_h1});
    assign c9_hsub = c9_hm >>> 4;

    logic [63:0]        r9_mn, r9_md;
    logic               r9_neg, r9_zero;
    logic signed [31:0] r9_hv2, r9_hsub, r9_tc, r9_tf;

    // ------------------------------------------------------------------------
    // Stage 10: humidity clamp to 0..100 %RH.
    // ------------------------------------------------------------------------
    logic signed [31:0] c10_v;
    logic [31:0]        c10_cl;

    assign c10_v = r9_hv2 - r9_hsub;

    always_comb begin
        if (c10_v[31]) begin
            c10_cl = '0;
        end else if (c10_v > HUM_CLAMP) begin
            c10_cl = HUM_CLAMP;
        end else begin
            c10_cl = c10_v;
        end
    end

    logic [63:0] r10_mn, r10_md;
    t_side       r10_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_v1    <= c1_v1;
            r1_dd    <= c1_dd;
            r1_ap    <= i_adc_press;
            r1_ah    <= i_adc_hum;

            r2_tf    <= c2_tf;
            r2_ap    <= r1_ap;
            r2_ah    <= r1_ah;

            r3_tc    <= c3_tc;
            r3_tf    <= r2_tf;
            r3_x     <= c3_x;
            r3_hv    <= c3_hv;
            r3_ap    <= r2_ap;
            r3_ah    <= r2_ah;

            r4_sq    <= c4_sq;
            r4_xp5   <= c4_xp5;
            r4_xp2   <= c4_xp2;
            r4_h5v   <= c4_h5v;
            r4_b1    <= c4_b1;
            r4_b2    <= c4_b2;
            r4_tc    <= r3_tc;
            r4_tf    <= r3_tf;
            r4_ap    <= r3_ap;
            r4_ah    <= r3_ah;

            r5_x2a   <= c5_x2a;
            r5_y1    <= c5_y1;
            r5_xp5   <= r4_xp5;
            r5_xp2   <= r4_xp2;
            r5_a     <= c5_a;
            r5_b3    <= c5_b3;
            r5_tc    <= r4_tc;
            r5_tf    <= r4_tf;
            r5_ap    <= r4_ap;

            r6_x2    <= c6_x2;
            r6_y     <= c6_y;
            r6_a     <= r5_a;
            r6_hb    <= c6_hb;
            r6_tc    <= r5_tc;
            r6_tf    <= r5_tf;
            r6_ap    <= r5_ap;

            r7_nm    <= c7_nm;
            r7_z     <= c7_z;
            r7_hv2   <= c7_hv2;
            r7_tc    <= r6_tc;
            r7_tf    <= r6_tf;

            r8_num   <= c8_num;
            r8_z     <= r7_z;
            r8_hv2   <= r7_hv2;
            r8_ss7   <= c8_ss7;
            r8_tc    <= r7_tc;
            r8_tf    <= r7_tf;

            r9_mn    <= c9_mn;
            r9_md    <= c9_md;
            r9_neg   <= r8_num[63] ^ r8_z[63];
            r9_zero  <= (r8_z == 64'sd0);
            r9_hv2   <= r8_hv2;
            r9_hsub  <= c9_hsub;
            r9_tc    <= r8_tc;
            r9_tf    <= r8_tf;

            r10_mn        <= r9_mn;
            r10_md        <= r9_md;
            r10_side.neg  <= r9_neg;
            r10_side.zero <= r9_zero;
            r10_side.tc   <= r9_tc;
            r10_side.tf   <= r9_tf;
            r10_side.hum  <= c10_cl[28:12];
        end
    end

    // ------------------------------------------------------------------------
    // Pressure division: magnitudes in, quotient magnitude out.
    // ------------------------------------------------------------------------
    logic [63:0] div_quo;
    t_side       div_side;

    estc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vs[9]),
        .i_num   (r10_mn),
        .i_den   (r10_md),
        .i_side  (r10_side),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // ------------------------------------------------------------------------
    // Post stage 1: restore the quotient sign.
    // ------------------------------------------------------------------------
    logic [63:0] rp1_p;
    t_side       rp1_side;

    // Post stage 2: q = p >> 13, partial products of q*q, P8 term.
    logic signed [63:0] cp2_q, cp2_q8m, cp2_q8;
    logic [63:0]        cp2_lo;
    logic [31:0]        cp2_cr;

    assign cp2_q   = $signed(rp1_p) >>> 13;
    assign cp2_lo  = {32'd0, cp2_q[31:0]} * {32'd0, cp2_q[31:0]};
    assign cp2_cr  = cp2_q[63:32] * cp2_q[31:0];
    assign cp2_q8m = $signed(rp1_p) * 64'(tr_p8);
    assign cp2_q8  = cp2_q8m >>> 19;

    logic [63:0] rp2_p, rp2_lo, rp2_q8;
    logic [31:0] rp2_cr;
    t_side       rp2_side;

    // Post stage 3: low 64 bits of q*q from the partial products.
    logic [63:0] cp3_qq;

    assign cp3_qq = rp2_lo + {rp2_cr[30:0], 33'd0};

    logic [63:0] rp3_p, rp3_qq, rp3_q8;
    t_side       rp3_side;

    // Post stage 4: P9 term.
    logic signed [63:0] cp4_rm, cp4_rr;

    assign cp4_rm = $signed(rp3_qq) * 64'(tr_p9);
    assign cp4_rr = cp4_rm >>> 25;

    logic [63:0] rp4_p, rp4_rr, rp4_q8;
    t_side       rp4_side;

    // Post stage 5: final pressure; a zero divisor forces zero.
    logic [63:0] cp5_sum;
    logic [31:0] cp5_pq;

    assign cp5_sum = rp4_p + rp4_rr + rp4_q8;
    assign cp5_pq  = cp5_sum[39:8] + {{12{tr_p7[15]}}, tr_p7, 4'd0};

    logic [31:0] rp5_pq;
    t_side       rp5_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp1_p    <= div_side.neg ? (64'd0 - div_quo) : div_quo;
            rp1_side <= div_side;

            rp2_p    <= rp1_p;
            rp2_lo   <= cp2_lo;
            rp2_cr   <= cp2_cr;
            rp2_q8   <= cp2_q8;
            rp2_side <= rp1_side;

            rp3_p    <= rp2_p;
            rp3_qq   <= cp3_qq;
            rp3_q8   <= rp2_q8;
            rp3_side <= rp2_side;

            rp4_p    <= rp3_p;
            rp4_rr   <= cp4_rr;
            rp4_q8   <= rp3_q8;
            rp4_side <= rp3_side;

            rp5_pq   <= rp4_side.zero ? 32'd0 : cp5_pq;
            rp5_side <= rp4_side;
        end
    end

    // ------------------------------------------------------------------------
    // Result assembly: rounded whole-Pa and 0.01 %RH values.
    // ------------------------------------------------------------------------
    logic [31:0] c_pa_sum;
    logic [21:0] c_hc_sum;
    t_res        c_res;

    assign c_pa_sum = rp5_pq + 32'd128;
    assign c_hc_sum = {1'b0, rp5_side.hum, 4'd0} + {2'b00, rp5_side.hum, 3'd0}
                    + {5'd0, rp5_side.hum} + 22'd128;

    always_comb begin
        c_res.temp_centi    = rp5_side.tc;
        c_res.fine_temp     = rp5_side.tf;
        c_res.press_q24_8   = rp5_pq;
        c_res.hum_q22_10    = rp5_side.hum;
        c_res.press_pa      = c_pa_sum[31:8];
        c_res.hum_centi     = c_hc_sum[21:8];
        c_res.press_invalid = rp5_side.zero;
    end

    // ------------------------------------------------------------------------
    // Output register with one skid entry.
    // ------------------------------------------------------------------------
    logic r_out_vld;
    t_res r_out;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vp[4]) begin
            if (!r_out_vld || i_out_ready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (r_vp[4]) begin
            if (!r_out_vld || i_out_ready) begin
                r_out <= c_res;
            end else begin
                r_skid <= c_res;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_temp_centi    = r_out.temp_centi;
    assign o_fine_temp     = r_out.fine_temp;
    assign o_press_q24_8   = r_out.press_q24_8;
    assign o_hum_q22_10    = r_out.hum_q22_10;
    assign o_press_pa      = r_out.press_pa;
    assign o_hum_centi     = r_out.hum_centi;
    assign o_press_invalid = r_out.press_invalid;

endmodule

`default_nettype wire

// File: hdl/estc_div.sv
// ============================================================================
// estc_div: pipelined unsigned divider
// One restoring quotient bit per stage, one operand pair may enter every
// enabled cycle. The sideband record travels beside the operands.
// ============================================================================
`default_nettype none

module estc_div import estc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_vld,
    output logic [DIV_W-1:0] o_quo,
    output t_side            o_side
);

    logic [DIV_W-1:0] r_rem  [DIV_W];
    logic [DIV_W-1:0] r_nq   [DIV_W];
    logic [DIV_W-1:0] r_den  [DIV_W];
    t_side            r_side [DIV_W];
    logic [DIV_W-1:0] r_vld;

    logic [DIV_W-1:0] n_rem [DIV_W];
    logic [DIV_W-1:0] n_nq  [DIV_W];

    // Each stage shifts in the next numerator bit and subtracts if it fits.
    always_comb begin
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] nq;
        logic [DIV_W-1:0] den;
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   diff;
        for (int k = 0; k < DIV_W; k++) begin
            if (k == 0) begin
                rem = '0;
                nq  = i_num;
                den = i_den;
            end else begin
                rem = r_rem[k-1];
                nq  = r_nq[k-1];
                den = r_den[k-1];
            end
            trial    = {rem, nq[DIV_W-1]};
            diff     = trial - {1'b0, den};
            n_rem[k] = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
            n_nq[k]  = {nq[DIV_W-2:0], ~diff[DIV_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                if (k == 0) begin
                    r_den[k]  <= i_den;
                    r_side[k] <= i_side;
                end else begin
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_vld  = r_vld[DIV_W-1];
    assign o_quo  = r_nq[DIV_W-1];
    assign o_side = r_side[DIV_W-1];

endmodule

`default_nettype wire
